/* rtl/core/iq_pack_lane_reorder_assert.svh */
// assertion macros for the iq lane reorder block
// expects clk_i and rst_ni in the scope of use
`ifndef IQ_PACK_LANE_REORDER_ASSERT_SVH
`define IQ_PACK_LANE_REORDER_ASSERT_SVH

// combinational or implication property, checked on every clock
`define IQPLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define IQPLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/iqplr_pkg.sv */
// shared constants, types and the iq packing function for the lane reorder block
// no dependencies
package iqplr_pkg;

  localparam int DelayDepth      = 256;
  localparam int SamplesPerCycle = 8;
  localparam int OutLanes        = 16;
  localparam int SampleW         = 16;
  localparam int WordW           = 2 * SampleW;
  localparam int GroupW          = SamplesPerCycle * WordW;
  localparam int FieldW          = 64;
  localparam int FieldLanes      = FieldW / WordW;
  localparam int OutFields       = OutLanes / FieldLanes;
  localparam int CountW          = 9;
  localparam int PosW            = (DelayDepth > 1) ? $clog2(DelayDepth) : 1;

  localparam logic [CountW-1:0] LastCount = CountW'(511);
  localparam logic [PosW-1:0]   LastPos   = PosW'(DelayDepth - 1);

  typedef logic [SamplesPerCycle-1:0][WordW-1:0] group_t;
  typedef logic [OutLanes-1:0][WordW-1:0]        lanes_t;
  typedef logic [OutFields-1:0][FieldW-1:0]      fields_t;

  typedef struct packed {
    logic odd;
    logic last;
    logic primed;
  } info_t;

  function automatic group_t pack_group(input logic [FieldW-1:0] i_low,
                                        input logic [FieldW-1:0] i_high,
                                        input logic [FieldW-1:0] q_low,
                                        input logic [FieldW-1:0] q_high);
    logic [2*FieldW-1:0] i_all;
    logic [2*FieldW-1:0] q_all;
    group_t              grp;
    i_all = {i_high, i_low};
    q_all = {q_high, q_low};
    for (int k = 0; k < SamplesPerCycle; k++) begin
      grp[k] = {q_all[k*SampleW +: SampleW], i_all[k*SampleW +: SampleW]};
    end
    return grp;
  endfunction

endpackage

/* rtl/core/iqplr_delay_line.sv */
// one group delay line: circular memory read before write at the shift position
// depends on iqplr_pkg
module iqplr_delay_line (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic            wr_en_i,
  input  iqplr_pkg::group_t din_i,
  output iqplr_pkg::group_t dout_o
);
  import iqplr_pkg::*;

  logic [GroupW-1:0] mem_q [DelayDepth];
  logic [GroupW-1:0] rd_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              full_q, full_d;
  logic              rd_valid_q;

  always_comb begin
    pos_d  = pos_q;
    full_d = full_q;
    if (wr_en_i) begin
      if (pos_q == LastPos) begin
        pos_d  = '0;
        full_d = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[pos_q];
    end
    if (wr_en_i) begin
      mem_q[pos_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      full_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      full_q <= full_d;
      if (rd_en_i) begin
        rd_valid_q <= full_q;
      end
    end
  end

  // entries not yet written read as zero
  assign dout_o = rd_valid_q ? group_t'(rd_q) : '0;

endmodule

/* rtl/core/iqplr_out_stage.sv */
// lane selection, held group and result register with output handshake
// depends on iqplr_pkg
module iqplr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_valid_i,
  input  iqplr_pkg::info_t  info_i,
  input  iqplr_pkg::group_t grp_i,
  input  iqplr_pkg::group_t even_out_i,
  input  iqplr_pkg::group_t odd_out_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output iqplr_pkg::fields_t fields_o,
  output logic              frame_last_o
);
  import iqplr_pkg::*;

  group_t  held_q, held_d;
  group_t  upper;
  lanes_t  lanes;
  fields_t fields_q;
  logic    last_q;
  logic    valid_q;

  assign advance_o = s1_valid_i && (!valid_q || out_ready_i);
  assign upper     = info_i.odd ? grp_i : odd_out_i;
  assign held_d    = info_i.odd ? even_out_i : grp_i;
  assign lanes     = {upper, held_q};

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      fields_q <= info_i.primed ? fields_t'(lanes) : '0;
      last_q   <= info_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      held_q  <= '0;
    end else begin
      if (advance_o) begin
        valid_q <= 1'b1;
        held_q  <= held_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign fields_o     = fields_q;
  assign frame_last_o = last_q;

endmodule

/* rtl/core/iq_pack_lane_reorder.sv */
// iq pack and lane reorder top: input register, phase counter, two delay lines
// depends on iqplr_pkg, iqplr_delay_line, iqplr_out_stage, iq_pack_lane_reorder_assert.svh
//
// usage:
//   input channel in_valid_i / in_ready_o carries one word of eight I and eight Q
//   samples; output channel out_valid_o / out_ready_i carries sixteen packed
//   32-bit lanes plus frame_last_o
//   pipeline: an accepted word passes two register stages (input register with
//   delay line read, then result register)
//   throughput: one word per cycle while out_ready_i is high; set by the single read
//   and write port of each delay line, read on every accept, written on its phase
//   the odd-phase and even-phase delay lines each hold DelayDepth words and
//   shift only on words of their own phase
//   lanes read zero until the cycle counter has once reached 511; frame_last_o
//   marks count 511 from the first frame on
//   reset: counter, primed flag, held group and pipeline valids clear at once;
//   delay line entries read as zero until written, no clearing pass
//   stall: with out_ready_i low the result holds, one more word is taken into an empty
//   input register, then in_ready_o drops until the result is taken
module iq_pack_lane_reorder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] i_low_i,
  input  logic [63:0] i_high_i,
  input  logic [63:0] q_low_i,
  input  logic [63:0] q_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] lanes_0_1_o,
  output logic [63:0] lanes_2_3_o,
  output logic [63:0] lanes_4_5_o,
  output logic [63:0] lanes_6_7_o,
  output logic [63:0] lanes_8_9_o,
  output logic [63:0] lanes_10_11_o,
  output logic [63:0] lanes_12_13_o,
  output logic [63:0] lanes_14_15_o,
  output logic        frame_last_o
);
  import iqplr_pkg::*;

  logic              accept;
  logic              advance;
  logic              cur_odd;
  group_t            grp_in;
  group_t            grp_q;
  info_t             info_q;
  logic              s1_valid_q;
  logic [CountW-1:0] count_q;
  logic              primed_q;
  group_t            even_out;
  group_t            odd_out;
  fields_t           fields;

  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_odd    = count_q[0];
  assign grp_in     = pack_group(i_low_i, i_high_i, q_low_i, q_high_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q         <= grp_in;
      info_q.odd    <= cur_odd;
      info_q.last   <= (count_q == LastCount);
      info_q.primed <= primed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      primed_q   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        count_q    <= count_q + CountW'(1);
        if (count_q == LastCount) begin
          primed_q <= 1'b1;
        end
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  iqplr_delay_line u_even_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_en_i(accept),
    .wr_en_i(accept && !cur_odd),
    .din_i  (grp_in),
    .dout_o (even_out)
  );

  iqplr_delay_line u_odd_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_en_i(accept),
    .wr_en_i(accept && cur_odd),
    .din_i  (grp_in),
    .dout_o (odd_out)
  );

  iqplr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .info_i      (info_q),
    .grp_i       (grp_q),
    .even_out_i  (even_out),
    .odd_out_i   (odd_out),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .fields_o    (fields),
    .frame_last_o(frame_last_o)
  );

  assign lanes_0_1_o   = fields[0];
  assign lanes_2_3_o   = fields[1];
  assign lanes_4_5_o   = fields[2];
  assign lanes_6_7_o   = fields[3];
  assign lanes_8_9_o   = fields[4];
  assign lanes_10_11_o = fields[5];
  assign lanes_12_13_o = fields[6];
  assign lanes_14_15_o = fields[7];

`include "iq_pack_lane_reorder_assert.svh"

  `IQPLR_ASSERT(a_ready_when_out_empty, !out_valid_o |-> in_ready_o, "input stalled with empty output")
  `IQPLR_ASSERT_NEXT(a_primed_after_last, accept && (count_q == LastCount), primed_q, "primed flag not set after count 511")
  `IQPLR_ASSERT_NEXT(a_count_step, accept, count_q == $past(count_q) + CountW'(1), "cycle counter did not step on accept")
  `IQPLR_ASSERT(a_unprimed_zero, out_valid_o && !primed_q |-> fields == '0, "lanes nonzero before first frame")

endmodule

/* verif/iq_pack_lane_reorder_test.sv */
// testbench for the iq pack and lane reorder block: random and directed sample words,
// with idling on both sides, checked against a lane predictor held in the bench
// depends on iqplr_pkg and iq_pack_lane_reorder
`timescale 1ns / 1ps

module iq_pack_lane_reorder_test;
  import iqplr_pkg::*;

  typedef struct packed {
    logic [63:0] i_low;
    logic [63:0] i_high;
    logic [63:0] q_low;
    logic [63:0] q_high;
    logic        drain;
  } iq_word_t;

  typedef struct packed {
    fields_t lanes;
    logic    last;
  } lane_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [63:0] i_low_i       = '0;
  logic [63:0] i_high_i      = '0;
  logic [63:0] q_low_i       = '0;
  logic [63:0] q_high_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [63:0] lanes_0_1_o;
  logic [63:0] lanes_2_3_o;
  logic [63:0] lanes_4_5_o;
  logic [63:0] lanes_6_7_o;
  logic [63:0] lanes_8_9_o;
  logic [63:0] lanes_10_11_o;
  logic [63:0] lanes_12_13_o;
  logic [63:0] lanes_14_15_o;
  logic        frame_last_o;

  iq_word_t   words_pending[$];
  lane_word_t lanes_due[$];
  int         errors      = 0;
  int         words_sent  = 0;
  int         words_seen  = 0;
  int         hold_left   = 0;
  logic       hold_done   = 1'b0;

  // predictor state
  group_t             even_line[DelayDepth];
  group_t             odd_line[DelayDepth];
  group_t             held_grp;
  int                 even_wr;
  int                 odd_wr;
  logic [CountW-1:0]  phase;
  logic               primed;

  iq_pack_lane_reorder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .i_low_i       (i_low_i),
    .i_high_i      (i_high_i),
    .q_low_i       (q_low_i),
    .q_high_i      (q_high_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lanes_0_1_o   (lanes_0_1_o),
    .lanes_2_3_o   (lanes_2_3_o),
    .lanes_4_5_o   (lanes_4_5_o),
    .lanes_6_7_o   (lanes_6_7_o),
    .lanes_8_9_o   (lanes_8_9_o),
    .lanes_10_11_o (lanes_10_11_o),
    .lanes_12_13_o (lanes_12_13_o),
    .lanes_14_15_o (lanes_14_15_o),
    .frame_last_o  (frame_last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void clear_lanes_model();
    for (int d = 0; d < DelayDepth; d++) begin
      even_line[d] = '0;
      odd_line[d]  = '0;
    end
    held_grp = '0;
    even_wr  = 0;
    odd_wr   = 0;
    phase    = '0;
    primed   = 1'b0;
  endfunction

  function automatic lane_word_t predict_lanes(input logic [63:0] il, input logic [63:0] ih,
                                               input logic [63:0] ql, input logic [63:0] qh);
    logic [127:0] i_cat;
    logic [127:0] q_cat;
    group_t       grp;
    group_t       even_old;
    group_t       odd_old;
    lanes_t       lane;
    logic         odd_ph;
    lane_word_t   res;
    i_cat  = {ih, il};
    q_cat  = {qh, ql};
    odd_ph = phase[0];
    for (int k = 0; k < SamplesPerCycle; k++) begin
      grp[k][SampleW-1:0]     = i_cat[SampleW*k +: SampleW];
      grp[k][WordW-1:SampleW] = q_cat[SampleW*k +: SampleW];
    end
    even_old = even_line[even_wr];
    odd_old  = odd_line[odd_wr];
    if (odd_ph) begin
      odd_line[odd_wr] = grp;
      odd_wr = (odd_wr + 1) % DelayDepth;
    end else begin
      even_line[even_wr] = grp;
      even_wr = (even_wr + 1) % DelayDepth;
    end
    for (int k = 0; k < SamplesPerCycle; k++) begin
      lane[k]                   = held_grp[k];
      lane[SamplesPerCycle + k] = odd_ph ? grp[k] : odd_old[k];
    end
    for (int m = 0; m < OutFields; m++) begin
      res.lanes[m] = primed ? {lane[2*m+1], lane[2*m]} : 64'd0;
    end
    res.last = (phase == LastCount);
    held_grp = odd_ph ? even_old : grp;
    if (res.last) primed = 1'b1;
    phase = phase + 1'b1;
    return res;
  endfunction

  function automatic logic [63:0] four_samples(input logic [15:0] s0, input logic [15:0] s1,
                                               input logic [15:0] s2, input logic [15:0] s3);
    return {s3, s2, s1, s0};
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_field();
    if ($urandom_range(0, 9) < 7) return {$urandom, $urandom};
    return four_samples(rand_sample(), rand_sample(), rand_sample(), rand_sample());
  endfunction

  function automatic void queue_word(input logic [63:0] il, input logic [63:0] ih,
                                     input logic [63:0] ql, input logic [63:0] qh,
                                     input logic drain);
    iq_word_t w;
    w.i_low  = il;
    w.i_high = ih;
    w.q_low  = ql;
    w.q_high = qh;
    w.drain  = drain;
    words_pending.push_back(w);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : sender
    iq_word_t nxt;
    logic     steady;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        lanes_due.push_back(predict_lanes(i_low_i, i_high_i, q_low_i, q_high_i));
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        steady = (words_sent >= 280) && (words_sent < 480);
        if (words_pending.size() != 0 &&
            !(words_pending[0].drain && lanes_due.size() != 0) &&
            (steady || $urandom_range(0, 99) >= 14)) begin
          nxt = words_pending.pop_front();
          i_low_i    <= nxt.i_low;
          i_high_i   <= nxt.i_high;
          q_low_i    <= nxt.q_low;
          q_high_i   <= nxt.q_high;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_seen >= 300) begin
      hold_left <= 120;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_left == 0) &&
                     ((words_seen >= 600 && words_seen < 800) || $urandom_range(0, 99) >= 14);
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    lane_word_t want;
    fields_t    got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      got = {lanes_14_15_o, lanes_12_13_o, lanes_10_11_o, lanes_8_9_o,
             lanes_6_7_o, lanes_4_5_o, lanes_2_3_o, lanes_0_1_o};
      if (lanes_due.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
      end else begin
        want = lanes_due.pop_front();
        for (int m = 0; m < OutFields; m++) begin
          if (got[m] !== want.lanes[m]) begin
            $error("lanes_%0d_%0d expected %h actual %h", 2*m, 2*m+1, want.lanes[m], got[m]);
            errors++;
          end
        end
        if (frame_last_o !== want.last) begin
          $error("frame_last expected %b actual %b", want.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[iq_pack_lane_reorder] ERROR");
    $finish;
  end

  initial begin
    clear_lanes_model();
    queue_word('0, '0, '0, '0, 1'b0);
    queue_word('1, '1, '1, '1, 1'b0);
    queue_word('1, '1, '0, '0, 1'b0);
    queue_word('0, '0, '1, '1, 1'b0);
    queue_word({16{4'h5}}, {16{4'ha}}, {16{4'ha}}, {16{4'h5}}, 1'b0);
    queue_word({16{4'ha}}, {16{4'h5}}, {16{4'h5}}, {16{4'ha}}, 1'b0);
    queue_word({4{16'h8000}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h8000}}, 1'b0);
    queue_word({4{16'h0001}}, {4{16'hfffe}}, {4{16'h8001}}, {4{16'h0000}}, 1'b0);
    queue_word(four_samples(16'h1000, 16'h1101, 16'h1202, 16'h1303),
               four_samples(16'h1404, 16'h1505, 16'h1606, 16'h1707),
               four_samples(16'h2000, 16'h2101, 16'h2202, 16'h2303),
               four_samples(16'h2404, 16'h2505, 16'h2606, 16'h2707), 1'b0);
    for (int b = 0; b < 8; b++) begin
      queue_word(64'd1 << (8*b), 64'd1 << (8*b+7), 64'h8000_0000_0000_0000 >> (8*b),
                 ~(64'd1 << (8*b+3)), 1'b0);
    end
    queue_word('1, '0, '0, '1, 1'b0);
    queue_word('0, '1, '1, '0, 1'b0);
    // enough words to prime, mark a frame end and wrap the counter
    for (int n = 0; n < 681; n++) begin
      queue_word(rand_field(), rand_field(), rand_field(), rand_field(), n == 0 || n == 500);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (words_pending.size() != 0 || in_valid_i || lanes_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("[iq_pack_lane_reorder] OK");
    end else begin
      $display("[iq_pack_lane_reorder] ERROR");
    end
    $finish;
  end

endmodule
